// File: rtl/core/dfcm_pkg.sv
// Shared constants and types for the DFCM stride value predictor.
package dfcm_pkg;

  localparam int VAL_W         = 64;
  localparam int TABLE_ENTRIES = 65536;
  localparam int MAX_ORDER     = 3;

  // hash width is floor(log2(TABLE_ENTRIES)); table depth follows from it
  localparam int HASH_W     = $clog2(TABLE_ENTRIES + 1) - 1;
  localparam int TBL_DEPTH  = 1 << HASH_W;
  localparam int FOLD_CHUNKS = (VAL_W + HASH_W - 1) / HASH_W;

  localparam int ORDER_W  = 2;
  localparam int PERIOD_W = 6;
  localparam int CFG_W    = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_ORDER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_PERIOD  = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [HASH_W-1:0] hash_t;

  // one delta-table line
  typedef struct packed {
    val_t recent;
    val_t older;
  } line_t;

  // per-transaction context handed from the history unit to the table stage
  typedef struct packed {
    hash_t idx;
    val_t  last_value;
    val_t  delta;
  } item_t;

  typedef struct packed {
    val_t predict_older;
    val_t predict_recent;
  } result_t;

endpackage

// File: rtl/core/dfcm_delta_ram.sv
// Delta table: single write port, one registered read port (read-first).
module dfcm_delta_ram import dfcm_pkg::*; (
  input  logic  clk,
  input  logic  we,
  input  hash_t waddr,
  input  line_t wdata,
  input  logic  re,
  input  hash_t raddr,
  output line_t rdata
);

  line_t mem [TBL_DEPTH];
  line_t rdata_r;

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/dfcm_hist.sv
// History hashes, last value and update counter; forms the table index.
module dfcm_hist import dfcm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  val_t                value,
  input  logic [ORDER_W-1:0]  history_order,
  input  logic [PERIOD_W-1:0] shift_period,
  output item_t               item
);

  val_t                last_value_r, last_value_nxt;
  hash_t               hist_r [MAX_ORDER];
  hash_t               hist_nxt [MAX_ORDER];
  logic [PERIOD_W-1:0] cnt_r, cnt_nxt;
  logic [PERIOD_W-1:0] cnt_inc;
  val_t                delta;
  hash_t               fold;
  hash_t               idx;
  logic                do_shift;

  assign delta   = value - last_value_r;
  assign cnt_inc = cnt_r + PERIOD_W'(1);
  assign do_shift = (cnt_inc == shift_period);

  always_comb begin
    fold = '0;
    for (int i = 0; i < FOLD_CHUNKS; i++) begin
      fold = fold ^ HASH_W'(delta >> (i * HASH_W));
    end
  end

  // order zero acts as one, anything above the deepest history saturates
  always_comb begin
    idx = hist_r[0];
    for (int i = 0; i < MAX_ORDER; i++) begin
      if ((int'(history_order) == i + 1) ||
          (i == MAX_ORDER - 1 && int'(history_order) > MAX_ORDER)) begin
        idx = hist_r[i];
      end
    end
  end

  always_comb begin
    last_value_nxt = last_value_r;
    cnt_nxt        = cnt_r;
    for (int i = 0; i < MAX_ORDER; i++) begin
      hist_nxt[i] = hist_r[i];
    end
    if (accept) begin
      cnt_nxt = cnt_inc;
      if (do_shift) begin
        cnt_nxt        = '0;
        last_value_nxt = value;
        hist_nxt[0]    = fold;
        for (int i = 1; i < MAX_ORDER; i++) begin
          hist_nxt[i] = (hist_r[i-1] << 1) ^ fold;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_value_r <= '0;
      cnt_r        <= '0;
      for (int i = 0; i < MAX_ORDER; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      last_value_r <= last_value_nxt;
      cnt_r        <= cnt_nxt;
      for (int i = 0; i < MAX_ORDER; i++) begin
        hist_r[i] <= hist_nxt[i];
      end
    end
  end

  assign item.idx        = idx;
  assign item.last_value = last_value_r;
  assign item.delta      = delta;

endmodule

// File: rtl/core/dfcm_out_fifo.sv
// Result buffer between the table stage and the output channel.
module dfcm_out_fifo import dfcm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  result_t               push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output result_t               pop_data,
  output logic [FIFO_CNT_W-1:0] count
);

  result_t               buf_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;
  logic                  pop;

  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      cnt_r <= cnt_r + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_valid = (cnt_r != '0);
  assign pop_data  = buf_r[rd_ptr_r];
  assign count     = cnt_r;

endmodule

// File: rtl/core/dfcm_stride_value_predictor_top.sv
// Top level of the DFCM stride value predictor: config, table stage, forwarding.
// Results pass the table stage register into a 4-entry output buffer that absorbs stalls.
// Throughput: one transaction per cycle while the output buffer has a free slot;
// the delta-table read/write-back with a one-entry forward register closes the loop.
// Reset (synchronous, rst_n low) clears history, last value and counters, then a
// clearing pass writes zero to all 65536 table lines, one per cycle, in_tready low.
module dfcm_stride_value_predictor_top import dfcm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,   // [63:0] value
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [127:0]         out_tdata,  // [63:0] predict_recent, [127:64] predict_older
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wr_data
);

  logic [ORDER_W-1:0]    order_r;
  logic [PERIOD_W-1:0]   period_r;
  logic                  accept;
  item_t                 hist_item;
  item_t                 b_item_r;
  logic                  b_valid_r;
  line_t                 ram_rdata;
  line_t                 cur_line;
  line_t                 new_line;
  logic                  ram_we;
  hash_t                 ram_waddr;
  line_t                 ram_wdata;
  logic                  fwd_valid_r;
  hash_t                 fwd_idx_r;
  line_t                 fwd_line_r;
  logic                  clearing_r;
  hash_t                 clr_addr_r;
  result_t               result;
  result_t               fifo_data;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W:0]   in_flight;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r  <= ORDER_W'(1);
      period_r <= PERIOD_W'(1);
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_HISTORY_ORDER) begin
        order_r <= cfg_wr_data[ORDER_W-1:0];
      end else if (cfg_index == CFG_SHIFT_PERIOD) begin
        period_r <= cfg_wr_data[PERIOD_W-1:0];
      end
    end
  end

  // each accepted transaction needs a slot in the output buffer
  assign in_flight = {1'b0, fifo_count} + (FIFO_CNT_W + 1)'(b_valid_r);
  assign in_tready = !clearing_r && (in_flight < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
  assign accept    = in_tvalid && in_tready;

  dfcm_hist u_hist (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .value         (in_tdata),
    .history_order (order_r),
    .shift_period  (period_r),
    .item          (hist_item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_item_r <= hist_item;
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + HASH_W'(1);
      if (clr_addr_r == HASH_W'(TBL_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // the line written on the previous edge is not yet in the read data
  assign cur_line = (fwd_valid_r && fwd_idx_r == b_item_r.idx) ? fwd_line_r : ram_rdata;

  always_comb begin
    new_line = cur_line;
    if (cur_line.recent != b_item_r.delta) begin
      new_line.older  = cur_line.recent;
      new_line.recent = b_item_r.delta;
    end
  end

  assign result.predict_recent = b_item_r.last_value + cur_line.recent;
  assign result.predict_older  = b_item_r.last_value + cur_line.older;

  assign ram_we    = clearing_r || b_valid_r;
  assign ram_waddr = clearing_r ? clr_addr_r : b_item_r.idx;
  assign ram_wdata = clearing_r ? '0 : new_line;

  dfcm_delta_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (hist_item.idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else begin
      fwd_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      fwd_idx_r  <= b_item_r.idx;
      fwd_line_r <= new_line;
    end
  end

  dfcm_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (b_valid_r),
    .push_data (result),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (fifo_data),
    .count     (fifo_count)
  );

  assign out_tdata = {fifo_data.predict_older, fifo_data.predict_recent};

`ifndef NO_ASSERTIONS
  a_b_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> $past(in_tvalid && in_tready))
    else $error("table stage valid without an accepted transaction");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> fifo_count < FIFO_CNT_W'(FIFO_DEPTH))
    else $error("output buffer overflow");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !b_valid_r && !out_tvalid)
    else $error("transaction in flight during clearing pass");

  a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clearing_r) |-> clr_addr_r == '0)
    else $error("clearing pass ended early");
`endif

endmodule
